FILE: src/slot_pool_allocator_core_assert.svh
// Assertion macros shared by the slot pool allocator RTL.
// Expects signals named clock and reset in the module that uses them.
`ifndef SLOT_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define SLOT_POOL_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPA_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPA_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/spa_pkg.sv
// Shared types and constants for the slot pool allocator.
// No dependencies; imported by the engine and the top level.
`default_nettype none

package spa_pkg;

   localparam int unsigned CNT_W    = 9;
   localparam int unsigned SIZE_W   = 13;
   localparam int unsigned INDEX_W  = 8;
   localparam int unsigned OFFSET_W = 20;
   localparam int unsigned LIVE_W   = 9;

   localparam logic [CNT_W-1:0]  POOL_SLOTS_RESET = 9'd256;
   localparam logic [SIZE_W-1:0] SLOT_BYTES_RESET = 13'd64;
   localparam logic [LIVE_W-1:0] LIVE_MAX         = 9'h1FF;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_RESET = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_RANGE     = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_POOL_SLOTS = 1'b0,
      CSR_SLOT_BYTES = 1'b1
   } csr_index_type;

   typedef struct packed {
      status_type          status;
      logic [INDEX_W-1:0]  index;
      logic [LIVE_W-1:0]   live;
      logic                empty;
   } spa_result_type;

endpackage

`default_nettype wire

FILE: src/spa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                                      clock,
   input  wire logic                                      we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                          wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: src/spa_engine.sv
// Free list, bump counter and live count of the slot pool allocator.
// Depends on spa_pkg, spa_ram and the assertion macro header.
`default_nettype none
`include "slot_pool_allocator_core_assert.svh"

module spa_engine #(
   parameter int SLOTS = 256
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              accept,
   input  wire spa_pkg::cmd_type                  cmd,
   input  wire logic [spa_pkg::INDEX_W-1:0]       slot_index,
   input  wire logic [spa_pkg::CNT_W-1:0]         pool_slots,
   output logic                                   busy,
   output spa_pkg::spa_result_type                result
);

   import spa_pkg::*;

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LINK_W = IDX_W + 1;
   localparam logic [16:0] SLOTS_L = 17'(SLOTS);

   logic [IDX_W-1:0]  head_ff, head_in;
   logic              head_valid_ff, head_valid_in;
   logic [CNT_W-1:0]  bump_ff, bump_in;
   logic [LIVE_W-1:0] live_ff, live_in;
   logic              pending_ff, pending_in;

   logic              link_we;
   logic [LINK_W-1:0] link_wdata;
   logic [LINK_W-1:0] link_rdata;
   logic [CNT_W-1:0]  eff_count;
   logic [LIVE_W-1:0] live_up;
   logic [LIVE_W-1:0] live_down;

   // Each link entry holds {list end, next slot}.
   spa_ram #(
      .WIDTH (LINK_W),
      .DEPTH (SLOTS)
   ) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (IDX_W'(slot_index)),
      .wdata (link_wdata),
      .raddr (head_ff),
      .rdata (link_rdata)
   );

   assign eff_count  = ({8'd0, pool_slots} > SLOTS_L) ? CNT_W'(SLOTS_L) : pool_slots;
   assign live_up    = (live_ff != LIVE_MAX) ? live_ff + 9'd1 : live_ff;
   assign live_down  = (live_ff != 9'd0) ? live_ff - 9'd1 : live_ff;
   assign link_wdata = {~head_valid_ff, head_ff};

   always_comb begin
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      bump_in       = bump_ff;
      live_in       = live_ff;
      pending_in    = 1'b0;
      link_we       = 1'b0;
      result.status = ST_DONE;
      result.index  = '0;
      if (pending_ff) begin
         // Link of the popped head is back from the RAM: advance the head.
         head_in       = link_rdata[IDX_W-1:0];
         head_valid_in = ~link_rdata[IDX_W];
      end else if (accept) begin
         unique case (cmd)
            CMD_ALLOC: begin
               if (head_valid_ff) begin
                  result.index = INDEX_W'(head_ff);
                  pending_in   = 1'b1;
                  live_in      = live_up;
               end else if (bump_ff < eff_count) begin
                  result.index = bump_ff[INDEX_W-1:0];
                  bump_in      = bump_ff + 9'd1;
                  live_in      = live_up;
               end else begin
                  result.status = ST_EXHAUSTED;
               end
            end
            CMD_FREE: begin
               if ({1'b0, slot_index} < eff_count) begin
                  link_we       = 1'b1;
                  head_in       = IDX_W'(slot_index);
                  head_valid_in = 1'b1;
                  live_in       = live_down;
                  result.index  = slot_index;
               end else begin
                  result.status = ST_RANGE;
               end
            end
            CMD_RESET: begin
               head_in       = '0;
               head_valid_in = 1'b0;
               bump_in       = '0;
               live_in       = '0;
            end
            CMD_NONE: begin
            end
            default: begin
            end
         endcase
      end
      result.live  = live_in;
      result.empty = (live_in == 9'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         head_valid_ff <= 1'b0;
         bump_ff       <= '0;
         live_ff       <= '0;
         pending_ff    <= 1'b0;
      end else begin
         head_ff       <= head_in;
         head_valid_ff <= head_valid_in;
         bump_ff       <= bump_in;
         live_ff       <= live_in;
         pending_ff    <= pending_in;
      end
   end

   assign busy = pending_ff;

   `SPA_ASSERT_NXT(a_pending_one_cycle, pending_ff, !pending_ff, "pop wait lasted over one cycle")
   `SPA_ASSERT_IMP(a_pending_from_pop, pending_ff, $past(accept && cmd == CMD_ALLOC && head_valid_ff), "pop wait without a list pop")
   `SPA_ASSERT_IMP(a_bump_bound, 1'b1, ({8'd0, bump_ff} <= SLOTS_L), "bump counter beyond pool depth")

endmodule

`default_nettype wire

FILE: src/slot_pool_allocator_core.sv
// Top level of the slot pool allocator: configuration registers and result register.
// Depends on spa_pkg, spa_engine and the assertion macro header.
//
// Slot pool allocator. A command beat is taken at a rising edge where start is high
// and busy is low; its single result shows on the rsp_ ports in the next cycle,
// marked by rsp_valid for one cycle. The receiver cannot stall: every result must be
// captured in the cycle it is shown. Free, pool reset, unused commands, exhausted
// allocates and allocates served by the bump counter leave busy low and may
// follow back to back.
// An allocate that pops the free list holds busy high for the cycle after it
// while the popped slot's link returns from the link RAM through its
// registered read port. So the rate is one beat per cycle while busy is low, and
// no new beat is taken while busy is high. Link RAM entries are never read before
// a free has written them, so there is no clearing pass after reset. Configuration
// (pool slot count at index 0, bytes per slot at index 1) is written through csr_we
// and must change only while the block is idle. byte_offset is slot index times the
// slot size, low 20 bits; live_count saturates at 0 and 511.
`default_nettype none
`include "slot_pool_allocator_core_assert.svh"

module slot_pool_allocator_core #(
   parameter int SLOTS = 256
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire spa_pkg::cmd_type                 req_cmd,
   input  wire logic [spa_pkg::INDEX_W-1:0]      req_slot_index,
   output logic                                  rsp_valid,
   output spa_pkg::status_type                   rsp_status,
   output logic [spa_pkg::INDEX_W-1:0]           rsp_slot_index_res,
   output logic [spa_pkg::OFFSET_W-1:0]          rsp_byte_offset,
   output logic [spa_pkg::LIVE_W-1:0]            rsp_live_count,
   output logic                                  rsp_pool_empty,
   input  wire logic                             csr_we,
   input  wire spa_pkg::csr_index_type           csr_index,
   input  wire logic [spa_pkg::SIZE_W-1:0]       csr_wdata
);

   import spa_pkg::*;

   logic [CNT_W-1:0]    pool_slots_ff;
   logic [SIZE_W-1:0]   slot_bytes_ff;
   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;
   logic [LIVE_W-1:0]   rsp_live_ff;
   logic                rsp_empty_ff;

   logic                accept;
   logic                engine_busy;
   spa_result_type      result;
   logic [20:0]         product;

   // Take a beat only while the engine is not finishing a list pop.
   assign accept = start & ~engine_busy;

   spa_engine #(
      .SLOTS (SLOTS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .cmd        (req_cmd),
      .slot_index (req_slot_index),
      .pool_slots (pool_slots_ff),
      .busy       (engine_busy),
      .result     (result)
   );

   // 8 x 13 bit product; the result register follows directly.
   assign product = {13'd0, result.index} * {8'd0, slot_bytes_ff};

   // Configuration registers: hold until written.
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_slots_ff <= POOL_SLOTS_RESET;
         slot_bytes_ff <= SLOT_BYTES_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POOL_SLOTS: pool_slots_ff <= csr_wdata[CNT_W-1:0];
            CSR_SLOT_BYTES: slot_bytes_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Result strobe: high for exactly the cycle after an accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
      end
   end

   // Result payload: capture on accept, hold otherwise.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= result.status;
         rsp_index_ff  <= result.index;
         rsp_offset_ff <= product[OFFSET_W-1:0];
         rsp_live_ff   <= result.live;
         rsp_empty_ff  <= result.empty;
      end
   end

   assign busy               = engine_busy;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot_index_res = rsp_index_ff;
   assign rsp_byte_offset    = rsp_offset_ff;
   assign rsp_live_count     = rsp_live_ff;
   assign rsp_pool_empty     = rsp_empty_ff;

   `SPA_ASSERT_IMP(a_rsp_from_accept, rsp_valid_ff, $past(accept), "result strobe without an accepted beat")
   `SPA_ASSERT_NXT(a_busy_no_rsp, engine_busy, !rsp_valid_ff, "result strobe after a busy cycle")

endmodule

`default_nettype wire
